// ----- hdl/lpp_pkg.sv -----
// Shared types, widths, register indexes and status codes of the landmark
// pinhole projection block. No dependencies.
`default_nettype none
package lpp_pkg;

  localparam int unsigned IN_W            = 256;
  localparam int unsigned OUT_W           = 32;
  localparam int unsigned OUTU_W          = 3;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned DIV_QBITS       = 21;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_ROTATION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_OFFSET   = 3'd7;

  localparam logic [1:0] STATUS_VISIBLE = 2'd0;
  localparam logic [1:0] STATUS_BEHIND  = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [12:0] IMAGE_MAX = 13'd4096;

  typedef struct packed {
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic [19:0] center_x;
    logic [19:0] center_y;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [63:0] mount_rotation;
    logic [62:0] mount_offset;
  } lpp_cfg_t;

  localparam lpp_cfg_t CFG_RESET = '{
    focal_x:        24'd128000,
    focal_y:        24'd128000,
    center_x:       20'd81920,
    center_y:       20'd61440,
    image_width:    13'd640,
    image_height:   13'd480,
    mount_rotation: 64'h4000_0000_0000_0000,
    mount_offset:   63'd0
  };

  typedef struct packed {
    logic               behind;
    logic [33:0]        depth;
    logic signed [34:0] py;
    logic signed [34:0] pz;
  } lpp_point_t;

endpackage
`default_nettype wire

// ----- hdl/landmark_pinhole_projection_top.sv -----
// Top level of the landmark pinhole projection block: configuration
// registers, front end, queue and back end. Depends on lpp_pkg and submodules.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_tvalid / in_tready  | in_tdata: pose and landmark
//   out_    | out | out_tvalid / out_tready| out_tdata pixels, out_tuser flags
//   cfg_    | in  | cfg_wr_en              | cfg_index, cfg_wdata
//
// One item per cycle while the output is not stalled; the path holds 7 front
// stages, the queue and 24 back stages, 21 of them the one-bit-per-stage
// divider. Synchronous reset clears valid bits and the queue and loads
// CFG_RESET into the configuration registers. out_tready low holds the back
// end; the queue absorbs up to QUEUE_DEPTH items before in_tready drops.
`default_nettype none
module landmark_pinhole_projection_top #(
  parameter int unsigned QUEUE_DEPTH = lpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // qw, qx, qy, qz (16b), body px, py, pz, point x, y, z (32b)
  input  logic [lpp_pkg::IN_W-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_u (16b), pixel_v (16b)
  output logic [lpp_pkg::OUT_W-1:0]      out_tdata,
  // visible (1b), status (2b)
  output logic [lpp_pkg::OUTU_W-1:0]     out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpp_pkg::*;

  lpp_cfg_t   cfg_r, cfg_nxt;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  lpp_point_t fq_item, qb_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOCAL_X:        cfg_nxt.focal_x        = cfg_wdata[23:0];
        REG_FOCAL_Y:        cfg_nxt.focal_y        = cfg_wdata[23:0];
        REG_CENTER_X:       cfg_nxt.center_x       = cfg_wdata[19:0];
        REG_CENTER_Y:       cfg_nxt.center_y       = cfg_wdata[19:0];
        REG_IMAGE_WIDTH:    cfg_nxt.image_width    = cfg_wdata[12:0];
        REG_IMAGE_HEIGHT:   cfg_nxt.image_height   = cfg_wdata[12:0];
        REG_MOUNT_ROTATION: cfg_nxt.mount_rotation = cfg_wdata;
        REG_MOUNT_OFFSET:   cfg_nxt.mount_offset   = cfg_wdata[62:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lpp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .cfg      (cfg_r),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  lpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  lpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- hdl/lpp_front.sv -----
// Front end: pose composition and transform of the landmark into camera
// coordinates, seven stages, depth classification. Depends on lpp_pkg.
`default_nettype none
module lpp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lpp_pkg::IN_W-1:0]  in_data,
  input  lpp_pkg::lpp_cfg_t         cfg,
  output logic                      q_valid,
  input  logic                      q_ready,
  output lpp_pkg::lpp_point_t       q_item
);
  import lpp_pkg::*;

  localparam int unsigned NSTAGE = 7;
  localparam logic signed [46:0] PC_MAX = 47'sd17179869183;
  localparam logic signed [46:0] PC_MIN = -47'sd17179869183;

  typedef logic [8:0][28:0] mat9_t;

  function automatic logic [28:0] rnd12(input logic signed [40:0] s);
    logic signed [40:0] t;
    t = s + 41'sd2048;
    return t[40:12];
  endfunction

  // products ordered xx yy zz xy xz yz wx wy wz
  function automatic mat9_t rotmat(input logic signed [40:0] p [9]);
    logic signed [40:0] one;
    mat9_t m;
    one = 41'sh10000000;
    m[0] = rnd12(one - ((p[1] + p[2]) <<< 1));
    m[1] = rnd12((p[3] - p[8]) <<< 1);
    m[2] = rnd12((p[4] + p[7]) <<< 1);
    m[3] = rnd12((p[3] + p[8]) <<< 1);
    m[4] = rnd12(one - ((p[0] + p[2]) <<< 1));
    m[5] = rnd12((p[5] - p[6]) <<< 1);
    m[6] = rnd12((p[4] - p[7]) <<< 1);
    m[7] = rnd12((p[5] + p[6]) <<< 1);
    m[8] = rnd12(one - ((p[0] + p[1]) <<< 1));
    return m;
  endfunction

  logic               en;
  logic [NSTAGE-1:0]  vld_r, vld_nxt;

  logic signed [31:0] a_qq_r [16], a_qq_nxt [16];
  logic signed [31:0] a_bp_r [9],  a_bp_nxt [9];
  logic [191:0]       a_pos_r, b_pos_r, c_pos_r, d_pos_r;
  logic signed [19:0] b_qc_r [4],  b_qc_nxt [4];
  mat9_t              b_mb_r, b_mb_nxt;
  logic signed [39:0] c_cp_r [9],  c_cp_nxt [9];
  logic signed [44:0] c_op_r [9],  c_op_nxt [9];
  mat9_t              d_mc_r, d_mc_nxt, e_mc_r;
  logic signed [28:0] d_tmp_r [3], d_tmp_nxt [3];
  logic signed [33:0] e_d_r [3],   e_d_nxt [3];
  logic signed [62:0] f_fp_r [9],  f_fp_nxt [9];
  lpp_point_t         g_item_r, g_item_nxt;

  assign en       = q_ready;
  assign in_ready = en;
  assign q_valid  = vld_r[NSTAGE-1];
  assign q_item   = g_item_r;
  assign vld_nxt  = {vld_r[NSTAGE-2:0], in_valid};

  always_comb begin
    logic signed [15:0] qb [4];
    logic signed [15:0] qm [4];
    for (int i = 0; i < 4; i++) begin
      qb[i] = in_data[16*i +: 16];
      qm[i] = cfg.mount_rotation[48-16*i +: 16];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        a_qq_nxt[4*i+j] = qb[i] * qm[j];
      end
    end
    a_bp_nxt[0] = qb[1] * qb[1];
    a_bp_nxt[1] = qb[2] * qb[2];
    a_bp_nxt[2] = qb[3] * qb[3];
    a_bp_nxt[3] = qb[1] * qb[2];
    a_bp_nxt[4] = qb[1] * qb[3];
    a_bp_nxt[5] = qb[2] * qb[3];
    a_bp_nxt[6] = qb[0] * qb[1];
    a_bp_nxt[7] = qb[0] * qb[2];
    a_bp_nxt[8] = qb[0] * qb[3];
  end

  always_comb begin
    logic signed [33:0] e34 [16];
    logic signed [33:0] s [4];
    logic signed [40:0] bp41 [9];
    for (int i = 0; i < 16; i++) begin
      e34[i] = a_qq_r[i];
    end
    s[0] = e34[0] - e34[5] - e34[10] - e34[15] + 34'sd8192;
    s[1] = e34[1] + e34[4] + e34[11] - e34[14] + 34'sd8192;
    s[2] = e34[2] - e34[7] + e34[8]  + e34[13] + 34'sd8192;
    s[3] = e34[3] + e34[6] - e34[9]  + e34[12] + 34'sd8192;
    for (int i = 0; i < 4; i++) begin
      b_qc_nxt[i] = s[i][33:14];
    end
    for (int k = 0; k < 9; k++) begin
      bp41[k] = a_bp_r[k];
    end
    b_mb_nxt = rotmat(bp41);
  end

  always_comb begin
    logic signed [21:0] mv;
    logic signed [20:0] ov;
    c_cp_nxt[0] = b_qc_r[1] * b_qc_r[1];
    c_cp_nxt[1] = b_qc_r[2] * b_qc_r[2];
    c_cp_nxt[2] = b_qc_r[3] * b_qc_r[3];
    c_cp_nxt[3] = b_qc_r[1] * b_qc_r[2];
    c_cp_nxt[4] = b_qc_r[1] * b_qc_r[3];
    c_cp_nxt[5] = b_qc_r[2] * b_qc_r[3];
    c_cp_nxt[6] = b_qc_r[0] * b_qc_r[1];
    c_cp_nxt[7] = b_qc_r[0] * b_qc_r[2];
    c_cp_nxt[8] = b_qc_r[0] * b_qc_r[3];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mv = b_mb_r[3*r+c][21:0];
        ov = cfg.mount_offset[42-21*c +: 21];
        c_op_nxt[3*r+c] = mv * ov;
      end
    end
  end

  always_comb begin
    logic signed [40:0] cp41 [9];
    logic signed [44:0] s45;
    for (int k = 0; k < 9; k++) begin
      cp41[k] = c_cp_r[k];
    end
    d_mc_nxt = rotmat(cp41);
    for (int r = 0; r < 3; r++) begin
      s45 = c_op_r[3*r] + c_op_r[3*r+1] + c_op_r[3*r+2] + 45'sd32768;
      d_tmp_nxt[r] = s45[44:16];
    end
  end

  always_comb begin
    logic signed [33:0] pb34, pt34, tm34;
    for (int i = 0; i < 3; i++) begin
      pb34 = $signed(d_pos_r[32*i +: 32]);
      pt34 = $signed(d_pos_r[96+32*i +: 32]);
      tm34 = d_tmp_r[i];
      e_d_nxt[i] = pt34 - (pb34 + tm34);
    end
  end

  always_comb begin
    logic signed [27:0] mv;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mv = e_mc_r[3*c+r][27:0];
        f_fp_nxt[3*r+c] = mv * e_d_r[c];
      end
    end
  end

  always_comb begin
    logic signed [62:0] s63;
    logic signed [46:0] v47;
    logic signed [34:0] pc [3];
    for (int r = 0; r < 3; r++) begin
      s63 = f_fp_r[3*r] + f_fp_r[3*r+1] + f_fp_r[3*r+2] + 63'sd32768;
      v47 = s63[62:16];
      if (v47 > PC_MAX) begin
        pc[r] = PC_MAX[34:0];
      end else if (v47 < PC_MIN) begin
        pc[r] = PC_MIN[34:0];
      end else begin
        pc[r] = v47[34:0];
      end
    end
    g_item_nxt.behind = pc[0][34] || (pc[0] == 35'sd0);
    g_item_nxt.depth  = pc[0][33:0];
    g_item_nxt.py     = pc[1];
    g_item_nxt.pz     = pc[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_qq_r   <= a_qq_nxt;
      a_bp_r   <= a_bp_nxt;
      a_pos_r  <= in_data[255:64];
      b_qc_r   <= b_qc_nxt;
      b_mb_r   <= b_mb_nxt;
      b_pos_r  <= a_pos_r;
      c_cp_r   <= c_cp_nxt;
      c_op_r   <= c_op_nxt;
      c_pos_r  <= b_pos_r;
      d_mc_r   <= d_mc_nxt;
      d_tmp_r  <= d_tmp_nxt;
      d_pos_r  <= c_pos_r;
      e_d_r    <= e_d_nxt;
      e_mc_r   <= d_mc_r;
      f_fp_r   <= f_fp_nxt;
      g_item_r <= g_item_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lpp_queue.sv -----
// Short register queue between front and back end, one write and one read
// per cycle. Depends on lpp_pkg.
`default_nettype none
module lpp_queue #(
  parameter int unsigned DEPTH = lpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpp_pkg::lpp_point_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lpp_pkg::lpp_point_t out_item
);
  import lpp_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lpp_point_t      mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lpp_back.sv -----
// Back end: focal scaling, two pipelined restoring dividers (one quotient
// bit per stage), image bounds and output register. Depends on lpp_pkg.
`default_nettype none
module lpp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  lpp_pkg::lpp_point_t           q_item,
  input  lpp_pkg::lpp_cfg_t             cfg,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lpp_pkg::OUT_W-1:0]     out_tdata,
  output logic [lpp_pkg::OUTU_W-1:0]    out_tuser
);
  import lpp_pkg::*;

  localparam int unsigned QB = DIV_QBITS;

  logic               en;
  logic               h_vld_r;
  logic signed [59:0] h_nu_r, h_nu_nxt, h_nv_r, h_nv_nxt;
  logic [33:0]        h_depth_r;
  logic               h_behind_r;

  logic               vld_r    [QB+1];
  logic [33:0]        depth_r  [QB+1], depth_nxt [QB+1];
  logic               behind_r [QB+1], behind_nxt [QB+1];
  logic [33:0]        rem_r [2][QB+1], rem_nxt [2][QB+1];
  logic [QB-1:0]      low_r [2][QB+1], low_nxt [2][QB+1];
  logic [QB-1:0]      quo_r [2][QB+1], quo_nxt [2][QB+1];
  logic               neg_r [2][QB+1], neg_nxt [2][QB+1];
  logic               ovf_r [2][QB+1], ovf_nxt [2][QB+1];

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;
  logic [OUTU_W-1:0]  out_user_r, out_user_nxt;

  assign en         = !out_valid_r || out_tready;
  assign q_ready    = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign h_nu_nxt = $signed({1'b0, cfg.focal_x}) * q_item.py;
  assign h_nv_nxt = $signed({1'b0, cfg.focal_y}) * q_item.pz;

  always_comb begin
    logic [59:0] n, a, lim;
    logic [34:0] t;
    lim = 60'(h_depth_r) << QB;
    for (int l = 0; l < 2; l++) begin
      n = (l == 0) ? h_nu_r : h_nv_r;
      neg_nxt[l][0] = n[59];
      a = n[59] ? ~n : n;
      ovf_nxt[l][0] = (a >= lim);
      rem_nxt[l][0] = a[QB +: 34];
      low_nxt[l][0] = a[QB-1:0];
      quo_nxt[l][0] = '0;
      for (int k = 1; k <= QB; k++) begin
        t = {rem_r[l][k-1], low_r[l][k-1][QB-1]};
        if (t >= {1'b0, depth_r[k-1]}) begin
          rem_nxt[l][k] = 34'(t - {1'b0, depth_r[k-1]});
          quo_nxt[l][k] = {quo_r[l][k-1][QB-2:0], 1'b1};
        end else begin
          rem_nxt[l][k] = t[33:0];
          quo_nxt[l][k] = {quo_r[l][k-1][QB-2:0], 1'b0};
        end
        low_nxt[l][k] = {low_r[l][k-1][QB-2:0], 1'b0};
        neg_nxt[l][k] = neg_r[l][k-1];
        ovf_nxt[l][k] = ovf_r[l][k-1];
      end
    end
    depth_nxt[0]  = h_depth_r;
    behind_nxt[0] = h_behind_r;
    for (int k = 1; k <= QB; k++) begin
      depth_nxt[k]  = depth_r[k-1];
      behind_nxt[k] = behind_r[k-1];
    end
  end

  always_comb begin
    logic [12:0] wlim, hlim;
    logic [21:0] lim22 [2];
    logic [19:0] cen [2];
    logic [QB:0] q1;
    logic [QB+1:0] u8 [2];
    logic outside [2];
    logic [1:0] status;
    wlim = (cfg.image_width > IMAGE_MAX) ? IMAGE_MAX : cfg.image_width;
    hlim = (cfg.image_height > IMAGE_MAX) ? IMAGE_MAX : cfg.image_height;
    lim22[0] = {1'b0, wlim, 8'd0};
    lim22[1] = {1'b0, hlim, 8'd0};
    cen[0] = cfg.center_x;
    cen[1] = cfg.center_y;
    for (int l = 0; l < 2; l++) begin
      q1 = neg_r[l][QB] ? ~{1'b0, quo_r[l][QB]} : {1'b0, quo_r[l][QB]};
      u8[l] = {q1[QB], q1} + (QB+2)'(cen[l]);
      outside[l] = ovf_r[l][QB] || u8[l][QB+1] || (u8[l][21:0] >= lim22[l]);
    end
    if (behind_r[QB]) begin
      status = STATUS_BEHIND;
    end else if (outside[0] || outside[1]) begin
      status = STATUS_OUTSIDE;
    end else begin
      status = STATUS_VISIBLE;
    end
    out_user_nxt = {status, status == STATUS_VISIBLE};
    if (status == STATUS_VISIBLE) begin
      out_data_nxt = {u8[1][19:4], u8[0][19:4]};
    end else begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r     <= 1'b0;
      vld_r       <= '{default: 1'b0};
      out_valid_r <= 1'b0;
    end else if (en) begin
      h_vld_r  <= q_valid;
      vld_r[0] <= h_vld_r;
      for (int k = 1; k <= QB; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_nu_r     <= h_nu_nxt;
      h_nv_r     <= h_nv_nxt;
      h_depth_r  <= q_item.depth;
      h_behind_r <= q_item.behind;
      depth_r    <= depth_nxt;
      behind_r   <= behind_nxt;
      rem_r      <= rem_nxt;
      low_r      <= low_nxt;
      quo_r      <= quo_nxt;
      neg_r      <= neg_nxt;
      ovf_r      <= ovf_nxt;
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lpp_checker.sv -----
// Port-level checks on the result channel of the projection block, bound to
// the top level. Depends on lpp_pkg.
`default_nettype none
module lpp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [lpp_pkg::OUT_W-1:0]  out_tdata,
  input logic [lpp_pkg::OUTU_W-1:0] out_tuser
);
  import lpp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_visible_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[2:1] == STATUS_VISIBLE)))
    else $error("visible flag disagrees with status");

  a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("rejected transaction carries pixel data");

endmodule

bind landmark_pinhole_projection_top lpp_checker u_lpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- verif/tb_landmark_pinhole_projection_top.sv -----
// Testbench for landmark_pinhole_projection_top: drives pose/landmark items
// and register writes, predicts pixels in fixed point and checks each result
// in order. Depends on lpp_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_landmark_pinhole_projection_top;
  import lpp_pkg::*;

  typedef struct packed {
    logic       visible;
    logic [1:0] status;
    logic [15:0] pixel_u;
    logic [15:0] pixel_v;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [OUTU_W-1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  landmark_pinhole_projection_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lpp_cfg_t cam;
  pixel_t pending_pixels[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint rnd(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic void rot_matrix(input longint q[4], output longint m[9]);
    longint one, w, x, y, z;
    one = longint'(1) <<< 28;
    w = q[0]; x = q[1]; y = q[2]; z = q[3];
    m[0] = rnd(one - 2 * (y * y + z * z), 12);
    m[1] = rnd(2 * (x * y - w * z), 12);
    m[2] = rnd(2 * (x * z + w * y), 12);
    m[3] = rnd(2 * (x * y + w * z), 12);
    m[4] = rnd(one - 2 * (x * x + z * z), 12);
    m[5] = rnd(2 * (y * z - w * x), 12);
    m[6] = rnd(2 * (x * z - w * y), 12);
    m[7] = rnd(2 * (y * z + w * x), 12);
    m[8] = rnd(one - 2 * (x * x + y * y), 12);
  endfunction

  function automatic pixel_t project_landmark(logic [IN_W-1:0] d);
    longint qb[4], qm[4], qc[4], pb[3], pt[3], off[3];
    longint mb[9], mc[9], tmp[3], dv[3], pc[3];
    longint wd, ht, u8, v8, lim;
    pixel_t r;
    lim = (longint'(1) <<< 34) - 1;
    for (int i = 0; i < 4; i++) begin
      qb[i] = longint'($signed(d[16*i +: 16]));
      qm[i] = longint'($signed(cam.mount_rotation[48-16*i +: 16]));
    end
    for (int i = 0; i < 3; i++) begin
      pb[i] = longint'($signed(d[64+32*i +: 32]));
      pt[i] = longint'($signed(d[160+32*i +: 32]));
      off[i] = longint'($signed(cam.mount_offset[42-21*i +: 21]));
    end
    wd = cam.image_width > 4096 ? 4096 : cam.image_width;
    ht = cam.image_height > 4096 ? 4096 : cam.image_height;
    qc[0] = rnd(qb[0]*qm[0] - qb[1]*qm[1] - qb[2]*qm[2] - qb[3]*qm[3], 14);
    qc[1] = rnd(qb[0]*qm[1] + qb[1]*qm[0] + qb[2]*qm[3] - qb[3]*qm[2], 14);
    qc[2] = rnd(qb[0]*qm[2] - qb[1]*qm[3] + qb[2]*qm[0] + qb[3]*qm[1], 14);
    qc[3] = rnd(qb[0]*qm[3] + qb[1]*qm[2] - qb[2]*qm[1] + qb[3]*qm[0], 14);
    rot_matrix(qb, mb);
    rot_matrix(qc, mc);
    for (int i = 0; i < 3; i++)
      tmp[i] = rnd(mb[3*i]*off[0] + mb[3*i+1]*off[1] + mb[3*i+2]*off[2], 16);
    for (int i = 0; i < 3; i++) dv[i] = pt[i] - (pb[i] + tmp[i]);
    for (int i = 0; i < 3; i++) begin
      pc[i] = rnd(mc[i]*dv[0] + mc[3+i]*dv[1] + mc[6+i]*dv[2], 16);
      if (pc[i] > lim) pc[i] = lim;
      if (pc[i] < -lim) pc[i] = -lim;
    end
    r = '0;
    if (pc[0] <= 0) begin
      r.status = STATUS_BEHIND;
      return r;
    end
    u8 = fdiv(longint'(cam.focal_x) * pc[1], pc[0]) + longint'(cam.center_x);
    v8 = fdiv(longint'(cam.focal_y) * pc[2], pc[0]) + longint'(cam.center_y);
    if (u8 < 0 || u8 >= wd * 256 || v8 < 0 || v8 >= ht * 256) begin
      r.status = STATUS_OUTSIDE;
      return r;
    end
    r.visible = 1'b1;
    r.status = STATUS_VISIBLE;
    r.pixel_u = 16'(u8 >>> 4);
    r.pixel_v = 16'(v8 >>> 4);
    return r;
  endfunction

  task automatic send_pose(logic [IN_W-1:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pixels.insert(pending_pixels.size(), project_landmark(d));
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[2:1], out_tdata[15:0], out_tdata[31:16]};
      if (pending_pixels.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.visible !== want.visible) begin
          $error("visible exp %0d got %0d", want.visible, got.visible); errors++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.pixel_u !== want.pixel_u) begin
          $error("pixel_u exp %0d got %0d", want.pixel_u, got.pixel_u); errors++;
        end
        if (got.pixel_v !== want.pixel_v) begin
          $error("pixel_v exp %0d got %0d", want.pixel_v, got.pixel_v); errors++;
        end
      end
    end
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FOCAL_X:        cam.focal_x = val[23:0];
      REG_FOCAL_Y:        cam.focal_y = val[23:0];
      REG_CENTER_X:       cam.center_x = val[19:0];
      REG_CENTER_Y:       cam.center_y = val[19:0];
      REG_IMAGE_WIDTH:    cam.image_width = val[12:0];
      REG_IMAGE_HEIGHT:   cam.image_height = val[12:0];
      REG_MOUNT_ROTATION: cam.mount_rotation = val;
      REG_MOUNT_OFFSET:   cam.mount_offset = val[62:0];
      default: begin
      end
    endcase
  endtask

  task automatic finish_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_quat();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [IN_W-1:0] make_pose(logic [63:0] q, logic [31:0] bx,
      logic [31:0] by, logic [31:0] bz, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {z, y, x, bz, by, bx, q};
  endfunction

  function automatic logic [31:0] near(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // near-identity pose about half the time, landmark in front or behind; one item in ten fully random
  function automatic logic [IN_W-1:0] rand_pose();
    logic [63:0] q;
    int k;
    k = $urandom_range(9);
    if (k < 5) q = {16'sd0, 16'sd0, 16'sd0, 16'sd16384} ^ 64'($urandom_range(15));
    else q = {rand_quat(), rand_quat(), rand_quat(), rand_quat()};
    if ($urandom_range(9) == 0)
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
    return make_pose(q, near(1 << 17), near(1 << 17), near(1 << 17),
                     32'($urandom_range(1 << 20, 1 << 16)) ^ 32'($urandom_range(3) << 30),
                     near(1 << 19), near(1 << 19));
  endfunction

  task automatic test_directed();
    logic [63:0] qi;
    qi = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_pose(make_pose(qi, 0, 0, 0, 32'h10000, 0, 0));
    send_pose(make_pose(qi, 0, 0, 0, 32'h1, 0, 0));
    send_pose(make_pose(qi, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(qi, 0, 0, 0, 32'hFFFF0000, 0, 0));
    send_pose(make_pose(qi, 0, 0, 0, 32'h10000, 32'h10000, 0));
    send_pose(make_pose(qi, 0, 0, 0, 32'h10000, 0, 32'hFFFF0000));
    send_pose(make_pose(qi, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'h80000000, 32'h80000000));
    send_pose(make_pose(qi, 32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    send_pose(make_pose({4{16'sh4000}}, 0, 0, 0, 32'h10000, 0, 0));
    send_pose(make_pose({4{16'shC000}}, 0, 0, 0, 32'h10000, 0, 0));
    send_pose(make_pose({16'sh0, 16'sh0, 16'sh0, 16'shC000}, 0, 0, 0, 32'hFFFF0000, 0, 0));
    send_pose(make_pose(64'h0, 0, 0, 0, 32'h10000, 0, 0));
    send_pose(make_pose({4{16'sh7FFF}}, 0, 0, 0, 32'h10000, 32'hFFFF, 32'hFFFF));
    send_pose(make_pose({4{16'sh8000}}, 1, 1, 1, 32'h10000, 0, 0));
    drain();
  endtask

  task automatic run_random(int n);
    repeat (n) send_pose(rand_pose());
  endtask

  task automatic test_idling();
    int sp[4] = '{0, 70, 0, 29};
    int rp[4] = '{0, 0, 70, 29};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sp[p];
      recv_stall_pct = rp[p];
      run_random(200);
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_settings();
    write_reg(REG_FOCAL_X, 24'hFFFFFF);
    write_reg(REG_FOCAL_Y, 24'd0);
    write_reg(REG_CENTER_X, 20'hFFFFF);
    write_reg(REG_CENTER_Y, 20'd0);
    write_reg(REG_IMAGE_WIDTH, 13'd4096);
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    write_reg(REG_MOUNT_ROTATION, {16'sh0, 16'sh0, 16'sh0, 16'sh4000});
    write_reg(REG_MOUNT_OFFSET, {21'h0FFFFF, 21'h100000, 21'h1FFFFF});
    finish_writes();
    run_random(150);
    drain();
    write_reg(REG_FOCAL_X, 24'd256);
    write_reg(REG_FOCAL_Y, 24'd64000);
    write_reg(REG_CENTER_X, 20'd0);
    write_reg(REG_CENTER_Y, 20'hFFFFF);
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_MOUNT_ROTATION, 64'hFFFFFFFFFFFFFFFF);
    write_reg(REG_MOUNT_OFFSET, 63'h7FFFFFFFFFFFFFFF);
    finish_writes();
    run_random(100);
    drain();
    write_reg(REG_FOCAL_X, 24'd200000);
    write_reg(REG_FOCAL_Y, 24'd150000);
    write_reg(REG_CENTER_X, 20'd163840);
    write_reg(REG_CENTER_Y, 20'd122880);
    write_reg(REG_IMAGE_WIDTH, 13'd1280);
    write_reg(REG_IMAGE_HEIGHT, 13'd4096);
    write_reg(REG_MOUNT_ROTATION, {16'sh2D41, 16'sh0, 16'sh2D41, 16'sh0});
    write_reg(REG_MOUNT_OFFSET, {21'h004000, 21'h1F0000, 21'h000800});
    finish_writes();
    run_random(150);
    drain();
  endtask

  initial begin
    cam = CFG_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idling();
    test_settings();
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
